// File: rtl/core/peak_current_boost_regulator_core_assert.svh
// Assertion macros shared by the regulator core files.
// Depends on nothing; include by bare file name inside a module body.
`ifndef PEAK_CURRENT_BOOST_REGULATOR_CORE_ASSERT_SVH
`define PEAK_CURRENT_BOOST_REGULATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define PCBR_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcbr assertion failed");

// Next-cycle implication, disabled during reset.
`define PCBR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcbr assertion failed");

`else

`define PCBR_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define PCBR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/core/pcbr_pkg.sv
// Package for the peak-current boost regulator core: widths, codes, types.
// No dependencies; used by pcbr_if, pcbr_seq and the top core file.
`timescale 1ns / 1ps

package pcbr_pkg;

    localparam int ADC_BITS   = 12;
    localparam int TARGET_W   = 12;
    localparam int GAIN_W     = 16;
    localparam int CMD_W      = 20;
    localparam int CNT_W      = 16;
    localparam int ERR_W      = 13;
    localparam int DERR_W     = 14;
    localparam int DAC_W      = 10;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int PI_W       = GAIN_W + 1 + ERR_W;
    localparam int PP_W       = GAIN_W + 1 + DERR_W;
    localparam int SUM_W      = 32;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_TARGET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INT_GAIN       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_TIME_TICKS = 3'd4;

    // Reset values
    localparam logic [TARGET_W-1:0] TARGET_RESET   = 12'd2146;
    localparam logic [GAIN_W-1:0]   PROP_RESET     = 16'd780;
    localparam logic [GAIN_W-1:0]   INT_RESET      = 16'd178;
    localparam logic [CMD_W-1:0]    LIMIT_RESET    = 20'd952320;
    localparam logic [CNT_W-1:0]    OFF_TIME_RESET = 16'd350;
    localparam logic [CMD_W-1:0]    CMD_RESET      = 20'd10240;
    localparam logic [ADC_BITS-1:0] OV_THRESHOLD   = 12'd3500;

    typedef enum logic [OP_W-1:0] {
        OP_TICK   = 2'd0,
        OP_TRIP   = 2'd1,
        OP_SAMPLE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        PH_ON   = 2'd0,
        PH_OFF  = 2'd1,
        PH_WAIT = 2'd2
    } phase_t;

    // Per-event decode handed from the sequencer to the PI pipeline
    typedef struct packed {
        logic                     gate_on;
        logic                     start_conversion;
        logic                     loop_updated;
        logic                     over_voltage;
        logic signed [ERR_W-1:0]  err;
        logic signed [DERR_W-1:0] derr;
    } pcbr_ev_t;

endpackage

// File: rtl/core/pcbr_if.sv
// Valid/ready channel interfaces of the regulator core: event, result, config.
// Depends on pcbr_pkg for field widths.
`timescale 1ns / 1ps

interface pcbr_evt_if;
    logic                           valid;
    logic                           ready;
    logic [pcbr_pkg::OP_W-1:0]      opcode;
    logic [pcbr_pkg::ADC_BITS-1:0]  adc_value;

    modport source (output valid, output opcode, output adc_value, input ready);
    modport sink   (input valid, input opcode, input adc_value, output ready);
endinterface

interface pcbr_res_if;
    logic                          valid;
    logic                          ready;
    logic                          gate_on;
    logic [pcbr_pkg::DAC_W-1:0]    dac_code;
    logic [pcbr_pkg::CMD_W-1:0]    current_command;
    logic                          start_conversion;
    logic                          over_voltage;
    logic                          loop_updated;

    modport source (output valid, output gate_on, output dac_code,
                    output current_command, output start_conversion,
                    output over_voltage, output loop_updated, input ready);
    modport sink   (input valid, input gate_on, input dac_code,
                    input current_command, input start_conversion,
                    input over_voltage, input loop_updated, output ready);
endinterface

interface pcbr_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [pcbr_pkg::CFG_IDX_W-1:0]     index;
    logic [pcbr_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/pcbr_seq.sv
// Switching-cycle sequencer: phase, off-time counter, last sample, previous error.
// Depends on pcbr_pkg.
`timescale 1ns / 1ps

module pcbr_seq (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic [pcbr_pkg::OP_W-1:0]         opcode,
    input  logic [pcbr_pkg::ADC_BITS-1:0]     adc_value,
    input  logic [pcbr_pkg::TARGET_W-1:0]     voltage_target,
    input  logic [pcbr_pkg::CNT_W-1:0]        off_time_ticks,
    output pcbr_pkg::pcbr_ev_t                ev
);
    import pcbr_pkg::*;

    phase_t                   phase_reg;
    phase_t                   phase_next;
    logic [CNT_W-1:0]         counter_reg;
    logic [CNT_W-1:0]         counter_next;
    logic [ADC_BITS-1:0]      sample_reg;
    logic [ADC_BITS-1:0]      sample_next;
    logic signed [ERR_W-1:0]  error_prev_reg;
    logic signed [ERR_W-1:0]  error_prev_next;

    logic [CNT_W-1:0]         cmp;
    logic [CNT_W-1:0]         cnt_inc;
    logic                     do_trip;
    logic                     do_tick;
    logic                     do_sample;
    logic                     tick_done;
    logic signed [ERR_W-1:0]  err;

    assign cmp       = (off_time_ticks == '0) ? CNT_W'(1) : off_time_ticks;
    assign cnt_inc   = (counter_reg == '1) ? counter_reg : counter_reg + CNT_W'(1);
    assign tick_done = (cnt_inc >= cmp);
    assign do_trip   = (phase_reg == PH_ON)   && (opcode == OP_TRIP);
    assign do_tick   = (phase_reg == PH_OFF)  && (opcode == OP_TICK);
    assign do_sample = (phase_reg == PH_WAIT) && (opcode == OP_SAMPLE);
    assign err       = $signed({1'b0, voltage_target}) - $signed({1'b0, adc_value});

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_ON:
            begin
                if (opcode == OP_TRIP)
                    phase_next = PH_OFF;
            end
            PH_OFF:
            begin
                if ((opcode == OP_TICK) && tick_done)
                    phase_next = PH_WAIT;
            end
            PH_WAIT:
            begin
                if (opcode == OP_SAMPLE)
                    phase_next = PH_ON;
            end
            default:
            begin
                phase_next = PH_ON;
            end
        endcase
    end

    // Datapath next values and event decode
    always_comb
    begin
        counter_next    = counter_reg;
        sample_next     = sample_reg;
        error_prev_next = error_prev_reg;
        if (do_trip)
            counter_next = '0;
        if (do_tick)
            counter_next = cnt_inc;
        if (do_sample)
        begin
            sample_next     = adc_value;
            error_prev_next = err;
        end

        ev.gate_on          = (phase_next == PH_ON);
        ev.start_conversion = do_tick && tick_done;
        ev.loop_updated     = do_sample;
        ev.over_voltage     = (sample_next >= OV_THRESHOLD);
        ev.err              = err;
        ev.derr             = DERR_W'(err) - DERR_W'(error_prev_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_ON;
            counter_reg    <= '0;
            sample_reg     <= '0;
            error_prev_reg <= $signed({1'b0, TARGET_RESET});
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            counter_reg    <= counter_next;
            sample_reg     <= sample_next;
            error_prev_reg <= error_prev_next;
        end
    end

    `include "peak_current_boost_regulator_core_assert.svh"

    `PCBR_ASSERT_NEXT(a_wait_after_start, clk, rst_n, accept && ev.start_conversion, phase_reg == PH_WAIT)
    `PCBR_ASSERT_NEXT(a_hold_when_idle, clk, rst_n, !accept, $stable(phase_reg) && $stable(counter_reg))
    `PCBR_ASSERT_SAME(a_off_count_bound, clk, rst_n, phase_reg == PH_ON, ev.start_conversion == 1'b0)

endmodule

// File: rtl/core/peak_current_boost_regulator_core.sv
// An accepted event beat passes the stage 1, stage 2 and result registers. Throughput: one
// event per cycle while results are taken; the sequencer decides phase in the accept cycle,
// one stage forms both PI products, the next sums, clamps and loads the result register.
// Stages advance independently, so bubbles close up; input stays ready while a result waits
// until all stages fill. Reset (rst_n, async low) loads register defaults, switch on,
// command 10240. Depends on pcbr_pkg, pcbr_if.sv, pcbr_seq and the assertion header.
`timescale 1ns / 1ps

module peak_current_boost_regulator_core #(
    parameter int DAC_SHIFT = 10
) (
    input  logic          clk,
    input  logic          rst_n,
    pcbr_cfg_if.sink      cfg,
    pcbr_evt_if.sink      evt,
    pcbr_res_if.source    res
);
    import pcbr_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers; the port never stalls.
    // ------------------------------------------------------------------
    logic [TARGET_W-1:0] voltage_target_reg;
    logic [GAIN_W-1:0]   prop_gain_reg;
    logic [GAIN_W-1:0]   int_gain_reg;
    logic [CMD_W-1:0]    current_limit_reg;
    logic [CNT_W-1:0]    off_time_ticks_reg;
    logic                cfg_write;

    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid && cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            voltage_target_reg <= TARGET_RESET;
            prop_gain_reg      <= PROP_RESET;
            int_gain_reg       <= INT_RESET;
            current_limit_reg  <= LIMIT_RESET;
            off_time_ticks_reg <= OFF_TIME_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg.index)
                REG_VOLTAGE_TARGET: voltage_target_reg <= cfg.data[TARGET_W-1:0];
                REG_PROP_GAIN:      prop_gain_reg      <= cfg.data[GAIN_W-1:0];
                REG_INT_GAIN:       int_gain_reg       <= cfg.data[GAIN_W-1:0];
                REG_CURRENT_LIMIT:  current_limit_reg  <= cfg.data[CMD_W-1:0];
                REG_OFF_TIME_TICKS: off_time_ticks_reg <= cfg.data[CNT_W-1:0];
                default:            ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage enables: each stage moves when its successor is empty or moving.
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic res_valid_reg;
    logic en1;
    logic en2;
    logic en3;
    logic evt_accept;

    assign en3        = !res_valid_reg || res.ready;
    assign en2        = !s2_valid_reg || en3;
    assign en1        = !s1_valid_reg || en2;
    assign evt.ready  = en1;
    assign evt_accept = evt.valid && evt.ready;

    // ------------------------------------------------------------------
    // Sequencer: phase and error bookkeeping happen in the accept cycle.
    // ------------------------------------------------------------------
    pcbr_ev_t ev;

    pcbr_seq u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (evt_accept),
        .opcode         (evt.opcode),
        .adc_value      (evt.adc_value),
        .voltage_target (voltage_target_reg),
        .off_time_ticks (off_time_ticks_reg),
        .ev             (ev)
    );

    // ------------------------------------------------------------------
    // Stage 1: hold the decoded event.
    // ------------------------------------------------------------------
    pcbr_ev_t s1_ev_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en1)
            s1_valid_reg <= evt_accept;
    end

    always_ff @(posedge clk)
    begin
        if (evt_accept)
            s1_ev_reg <= ev;
    end

    // ------------------------------------------------------------------
    // Stage 2: integral and proportional products, in parallel.
    // ------------------------------------------------------------------
    logic signed [PI_W-1:0] prod_i_next;
    logic signed [PP_W-1:0] prod_p_next;
    logic signed [PI_W-1:0] s2_prod_i_reg;
    logic signed [PP_W-1:0] s2_prod_p_reg;
    logic                   s2_gate_reg;
    logic                   s2_start_reg;
    logic                   s2_upd_reg;
    logic                   s2_ov_reg;

    assign prod_i_next = $signed({1'b0, int_gain_reg})  * s1_ev_reg.err;
    assign prod_p_next = $signed({1'b0, prop_gain_reg}) * s1_ev_reg.derr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en2)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en2 && s1_valid_reg)
        begin
            s2_prod_i_reg <= prod_i_next;
            s2_prod_p_reg <= prod_p_next;
            s2_gate_reg   <= s1_ev_reg.gate_on;
            s2_start_reg  <= s1_ev_reg.start_conversion;
            s2_upd_reg    <= s1_ev_reg.loop_updated;
            s2_ov_reg     <= s1_ev_reg.over_voltage;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: sum onto the held command, clamp to [0, limit], form the DAC
    // code. The held command loads as an update beat leaves stage 2, so every
    // later beat reports the new value. The next update is at least three
    // events away (trip, tick, sample), long after this one has landed.
    // ------------------------------------------------------------------
    logic [CMD_W-1:0]        command_prev_reg;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] limit_ext;
    logic [CMD_W-1:0]        clamped;
    logic [CMD_W-1:0]        cmd_out;
    logic [CMD_W-1:0]        cmd_shifted;
    logic [DAC_W-1:0]        dac_next;
    logic                    cmd_load;

    assign sum = $signed({{(SUM_W-CMD_W){1'b0}}, command_prev_reg})
               + SUM_W'(s2_prod_i_reg)
               + SUM_W'(s2_prod_p_reg);
    assign limit_ext = $signed({{(SUM_W-CMD_W){1'b0}}, current_limit_reg});

    always_comb
    begin
        if (sum >= limit_ext)
            clamped = current_limit_reg;
        else if (sum <= $signed(SUM_W'(0)))
            clamped = '0;
        else
            clamped = sum[CMD_W-1:0];
    end

    assign cmd_load    = en3 && s2_valid_reg && s2_upd_reg;
    assign cmd_out     = s2_upd_reg ? clamped : command_prev_reg;
    assign cmd_shifted = cmd_out >> DAC_SHIFT;
    // Saturate when the shift leaves more bits than the DAC takes
    assign dac_next    = (|cmd_shifted[CMD_W-1:DAC_W]) ? '1 : cmd_shifted[DAC_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            command_prev_reg <= CMD_RESET;
        else if (cmd_load)
            command_prev_reg <= clamped;
    end

    // ------------------------------------------------------------------
    // Result register: drop the beat once taken, load the next when it moves.
    // ------------------------------------------------------------------
    logic             res_gate_reg;
    logic [DAC_W-1:0] res_dac_reg;
    logic [CMD_W-1:0] res_cmd_reg;
    logic             res_start_reg;
    logic             res_ov_reg;
    logic             res_upd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (en3)
            res_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en3 && s2_valid_reg)
        begin
            res_gate_reg  <= s2_gate_reg;
            res_dac_reg   <= dac_next;
            res_cmd_reg   <= cmd_out;
            res_start_reg <= s2_start_reg;
            res_ov_reg    <= s2_ov_reg;
            res_upd_reg   <= s2_upd_reg;
        end
    end

    assign res.valid            = res_valid_reg;
    assign res.gate_on          = res_gate_reg;
    assign res.dac_code         = res_dac_reg;
    assign res.current_command  = res_cmd_reg;
    assign res.start_conversion = res_start_reg;
    assign res.over_voltage     = res_ov_reg;
    assign res.loop_updated     = res_upd_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `include "peak_current_boost_regulator_core_assert.svh"

    `PCBR_ASSERT_NEXT(a_cmd_only_on_update, clk, rst_n, !cmd_load, $stable(command_prev_reg))
    `PCBR_ASSERT_NEXT(a_cmd_within_limit, clk, rst_n, cmd_load, command_prev_reg <= $past(current_limit_reg))
    `PCBR_ASSERT_SAME(a_update_turns_on, clk, rst_n, res_valid_reg && res_upd_reg, res_gate_reg && !res_start_reg)
    `PCBR_ASSERT_NEXT(a_result_reports_cmd, clk, rst_n, cmd_load, res_cmd_reg == command_prev_reg)

endmodule
